/* design/occupancy_grid_segment_collision_assert.svh */
// assertion macros for the occupancy grid block
`ifndef OCCUPANCY_GRID_SEGMENT_COLLISION_ASSERT_SVH
`define OCCUPANCY_GRID_SEGMENT_COLLISION_ASSERT_SVH
// implication checked every clock outside reset
`define OGS_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// next-cycle implication
`define OGS_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

/* design/ogsc_pkg.sv */
// package: constants, types and codes of the occupancy grid block
package ogsc_pkg;
	localparam int DefMaxHalf = 63;
	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_POINT = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_FREE = 2'd1;
	localparam logic [1:0] ST_OCCUPIED = 2'd2;
	localparam logic [1:0] REG_CELL = 2'd0;
	localparam logic [1:0] REG_HALF = 2'd1;
	localparam logic [1:0] REG_GROUND = 2'd2;
	localparam logic [1:0] REG_OVER = 2'd3;
	// request and response between sequencer and divider
	typedef struct packed {
		logic        start;
		logic [35:0] num;
		logic [17:0] den;
	} ogsc_div_req_t;
	typedef struct packed {
		logic        done;
		logic [35:0] quo;
	} ogsc_div_rsp_t;
endpackage

/* design/occupancy_grid_segment_collision.sv */
// occupancy grid segment collision: top level, sequencer and grid memory
// op0 clears every grid cell before the next word is taken
// op1 runs two serial 36-bit divides and then a read-modify-write of one cell
// op2 runs four divides, walks the cells and then loads the output register
// one item at a time; a held result stalls only the next check at its end
// reset: a clearing pass over all (2*MAX_HALF_CELLS+1)^2 cells runs before the first item
module occupancy_grid_segment_collision import ogsc_pkg::*; #(
	parameter int MAX_HALF_CELLS = DefMaxHalf
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	input  logic signed [15:0] height,
	input  logic signed [31:0] x2,
	input  logic signed [31:0] y2,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               collision
);
	localparam int Side = 2 * MAX_HALF_CELLS + 1;
	localparam int Depth = Side * Side;
	localparam int CW = $clog2(Side + 1);
	localparam int AW = $clog2(Depth);
	localparam int GW = $clog2(4 * MAX_HALF_CELLS + 4);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_DIV   = 9'b000000100,
		S_DWAIT = 9'b000001000,
		S_PRD   = 9'b000010000,
		S_PWR   = 9'b000100000,
		S_WRD   = 9'b001000000,
		S_WCHK  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;
	state_t state_q;

	logic [15:0] cell_q;
	logic [5:0]  half_q;
	logic signed [15:0] ground_q, over_q;
	logic signed [31:0] rx_q, ry_q;
	logic [1:0]  op_q;
	logic signed [31:0] cx_q, cy_q, gx_q, gy_q;
	logic signed [15:0] h_q;
	logic [1:0]  didx_q;
	logic [CW-1:0] ix_q [4];
	logic [AW-1:0] clr_q;
	logic [CW-1:0] px_q, py_q, qx_q, qy_q;
	logic [CW:0] adx_q, ady_q, kx_q, ky_q;
	logic sxn_q, syn_q;
	logic [GW-1:0] guard_q;
	logic hit_q;
	logic oval_q;
	logic coll_q;
	logic ofree;
	logic [1:0] mem [Depth];
	logic [1:0] rd_q;
	logic [AW-1:0] addr;
	logic we;
	logic [1:0] wd;

	ogsc_div_req_t dreq;
	ogsc_div_rsp_t drsp;
	ogsc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [15:0] ceff;
	logic [CW-1:0] heff;
	logic signed [31:0] dcoord, drobot;
	logic signed [35:0] nval;
	logic signed [35:0] q;
	logic signed [CW+1:0] hs;
	logic [CW-1:0] cidx;

	assign ceff = (cell_q == 16'd0) ? 16'd1 : cell_q;
	assign heff = (int'(half_q) > MAX_HALF_CELLS) ? CW'(MAX_HALF_CELLS) : CW'(half_q);
	always_comb begin
		case (didx_q)
			2'd0: begin dcoord = cx_q; drobot = rx_q; end
			2'd1: begin dcoord = cy_q; drobot = ry_q; end
			2'd2: begin dcoord = gx_q; drobot = rx_q; end
			default: begin dcoord = gy_q; drobot = ry_q; end
		endcase
	end
	assign nval = 36'(signed'({{4{dcoord[31]}}, dcoord}) - {{4{drobot[31]}}, drobot})
		* 36'sd2 + signed'({20'd0, ceff});
	assign dreq.start = (state_q == S_DIV);
	assign dreq.num = nval;
	assign dreq.den = {1'b0, ceff, 1'b0};
	assign q = signed'(drsp.quo);
	assign hs = signed'({2'b00, heff});
	always_comb begin
		if (q < -36'(hs)) cidx = '0;
		else if (q > 36'(hs)) cidx = CW'(2 * heff);
		else cidx = CW'(q + 36'(hs));
	end

	logic [CW:0] nkx, nky;
	logic [2*CW+2:0] lhs, rhs;
	logic stepx;
	logic [CW:0] nx, ny;
	assign nkx = kx_q + 1'b1;
	assign nky = ky_q + 1'b1;
	assign lhs = nkx * ady_q;
	assign rhs = nky * adx_q;
	assign stepx = (ady_q == '0) || (adx_q != '0 && lhs < rhs);
	assign nx = sxn_q ? ({1'b0, px_q} - 1'b1) : ({1'b0, px_q} + 1'b1);
	assign ny = syn_q ? ({1'b0, py_q} - 1'b1) : ({1'b0, py_q} + 1'b1);

	always_comb begin
		we = 1'b0;
		wd = ST_UNKNOWN;
		addr = AW'(px_q * Side + py_q);
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			addr = clr_q;
		end else if (state_q == S_PWR) begin
			if (h_q > ground_q && h_q < over_q) begin
				we = 1'b1;
				wd = ST_OCCUPIED;
			end else if (h_q <= ground_q && rd_q != ST_OCCUPIED) begin
				we = 1'b1;
				wd = ST_FREE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wd;
		rd_q <= mem[addr];
	end

	assign in_ready = (state_q == S_IDLE);
	assign ofree = !oval_q || out_ready;
	assign out_valid = oval_q;
	assign collision = coll_q;

	// output register, frees the sequencer while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
			coll_q <= 1'b0;
		end else if (state_q == S_OUT && ofree) begin
			oval_q <= 1'b1;
			coll_q <= hit_q;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= 16'd51;
			half_q <= 6'd63;
			ground_q <= 16'sd38;
			over_q <= 16'sd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELL: cell_q <= cfg_data;
				REG_HALF: half_q <= cfg_data[5:0];
				REG_GROUND: ground_q <= cfg_data;
				REG_OVER: over_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
			didx_q <= '0;
			hit_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(Depth - 1)) begin
						clr_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: if (in_valid) begin
					op_q <= op;
					cx_q <= x;
					cy_q <= y;
					gx_q <= x2;
					gy_q <= y2;
					h_q <= height;
					didx_q <= '0;
					case (op)
						OP_FRAME: begin
							rx_q <= x;
							ry_q <= y;
							state_q <= S_CLEAR;
						end
						OP_POINT, OP_CHECK: state_q <= S_DIV;
						default: ;
					endcase
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: if (drsp.done) begin
					ix_q[didx_q] <= cidx;
					didx_q <= didx_q + 1'b1;
					if (op_q == OP_POINT && didx_q == 2'd1) begin
						px_q <= ix_q[0];
						py_q <= cidx;
						state_q <= S_PRD;
					end else if (didx_q == 2'd3) begin
						px_q <= ix_q[0];
						py_q <= ix_q[1];
						qx_q <= ix_q[2];
						qy_q <= cidx;
						sxn_q <= ix_q[2] < ix_q[0];
						syn_q <= cidx < ix_q[1];
						adx_q <= (ix_q[2] < ix_q[0]) ? {1'b0, ix_q[0] - ix_q[2]}
							: {1'b0, ix_q[2] - ix_q[0]};
						ady_q <= (cidx < ix_q[1]) ? {1'b0, ix_q[1] - cidx}
							: {1'b0, cidx - ix_q[1]};
						kx_q <= '0;
						ky_q <= '0;
						guard_q <= '0;
						state_q <= S_WRD;
					end else state_q <= S_DIV;
				end
				S_PRD: state_q <= S_PWR;
				S_PWR: state_q <= S_IDLE;
				S_WRD: state_q <= S_WCHK;
				S_WCHK: begin
					if (rd_q == ST_OCCUPIED) begin
						hit_q <= 1'b1;
						state_q <= S_OUT;
					end else if ((px_q == qx_q && py_q == qy_q)
						|| int'(guard_q) >= 4 * MAX_HALF_CELLS + 3) begin
						hit_q <= 1'b0;
						state_q <= S_OUT;
					end else begin
						guard_q <= guard_q + 1'b1;
						if (stepx) begin
							px_q <= nx[CW-1:0];
							kx_q <= nkx;
						end else begin
							py_q <= ny[CW-1:0];
							ky_q <= nky;
						end
						if ((stepx && int'(nx) >= Side) || (!stepx && int'(ny) >= Side)) begin
							hit_q <= 1'b0;
							state_q <= S_OUT;
						end else state_q <= S_WRD;
					end
				end
				S_OUT: if (ofree) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "occupancy_grid_segment_collision_assert.svh"
	`OGS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(collision))
	`OGS_ASSERT_NXT(a_out_load, clk, arst_n, state_q == S_OUT && ofree, out_valid)
	`OGS_ASSERT_IMP(a_clear_busy, clk, arst_n, state_q == S_CLEAR, !in_ready)
endmodule

/* design/ogsc_div.sv */
// shared floor divider, one quotient bit per cycle
module ogsc_div import ogsc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ogsc_div_req_t req,
	output ogsc_div_rsp_t rsp
);
	logic [35:0] num_q;
	logic [35:0] quo_q;
	logic [36:0] rem_q;
	logic [17:0] den_q;
	logic        neg_q;
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [36:0] trial;
	logic [36:0] rsh;
	logic [35:0] qn;
	logic [35:0] qf;

	assign rsh = {rem_q[35:0], num_q[35]};
	assign trial = rsh - {19'd0, den_q};
	assign qn = {quo_q[34:0], !trial[36]};
	// floor for negative: -(ceil(|n|/d)) = ~trunc((|n|-1)/d)
	assign qf = neg_q ? ~quo_q : quo_q;
	assign rsp.done = done_q;
	assign rsp.quo = qf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd36;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[35];
			num_q <= req.num[35] ? (~req.num) : req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[34:0], 1'b0};
			rem_q <= trial[36] ? rsh : trial;
			quo_q <= qn;
		end
	end

	`include "occupancy_grid_segment_collision_assert.svh"
	`OGS_ASSERT_NXT(a_div_done, clk, arst_n, busy_q && cnt_q == 6'd1, done_q)
	`OGS_ASSERT_IMP(a_div_nostart, clk, arst_n, busy_q, !req.start)
	`OGS_ASSERT_IMP(a_div_excl, clk, arst_n, done_q, !busy_q)
endmodule

/* tb/sv/tb_top.sv */
// testbench for the occupancy grid block: directed table plus random traffic against a predictor
`timescale 1ns / 1ps
module tb_top;
	import ogsc_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int GRID_SIDE = 2 * DefMaxHalf + 1;
	localparam int CLEAR_WAIT = GRID_SIDE * GRID_SIDE + 600;
	localparam int CHECK_WAIT = 1500;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] h;
		logic [31:0] x2;
		logic [31:0] y2;
		bit          typed;
		bit          exp_hit;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] op;
	logic signed [31:0] x;
	logic signed [31:0] y;
	logic signed [15:0] height;
	logic signed [31:0] x2;
	logic signed [31:0] y2;
	logic out_valid;
	logic out_ready;
	logic collision;

	logic [1:0] grid_map [GRID_SIDE][GRID_SIDE];
	longint robot_px, robot_py;
	longint cell_len, half_len, ground_lim, over_lim;
	bit hit_queue [$];
	int errors = 0;
	longint cycles = 0;
	bit calm = 0;
	bit hold_go = 0;
	bit hold_done = 0;
	int hold_cnt = 0;

	plan_row_t plan [16] = '{
		'{OP_CHECK, 0, 0, 0, 0, 0, 1, 0},
		'{OP_POINT, 0, 0, 100, 0, 0, 0, 0},
		'{OP_CHECK, 0, 0, 0, 0, 0, 1, 1},
		'{OP_POINT, 32'h7fffffff, 32'h80000000, 16'h8000, 0, 0, 0, 0},
		'{OP_POINT, 32'h80000000, 32'h7fffffff, 16'h7fff, 0, 0, 0, 0},
		'{OP_POINT, 510, 0, 39, 0, 0, 0, 0},
		'{OP_POINT, 1020, 0, 256, 0, 0, 0, 0},
		'{OP_POINT, -510, 0, 38, 0, 0, 0, 0},
		'{OP_CHECK, -5000, 0, 0, 5000, 0, 1, 1},
		'{OP_SPARE, 1, 2, 3, 4, 5, 0, 0},
		'{OP_CHECK, 32'h80000000, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0, 0},
		'{OP_CHECK, 0, 32'hffffffff, 16'hffff, 0, 32'hffffffff, 0, 0},
		'{OP_FRAME, 1000, -1000, 0, 0, 0, 0, 0},
		'{OP_CHECK, 1000, -1000, 0, 1000, -1000, 1, 0},
		'{OP_POINT, 32'hffffffff, 32'hffffffff, 16'hffff, 32'hffffffff, 32'hffffffff, 0, 0},
		'{OP_CHECK, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0, 0}
	};

	occupancy_grid_segment_collision dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic longint bin_index(longint coord, longint robot);
		longint c, hc, n, den, q;
		c = (cell_len == 0) ? 1 : cell_len;
		hc = (half_len > DefMaxHalf) ? DefMaxHalf : half_len;
		n = 2 * (coord - robot) + c;
		den = 2 * c;
		q = n / den;
		if (n % den != 0 && n < 0) q--;
		if (q < -hc) q = -hc;
		if (q > hc) q = hc;
		return q + hc;
	endfunction

	function automatic bit walk_blocked(longint ox, longint oy, longint gx, longint gy);
		longint dx, dy, sx, sy, adx, ady, kx, ky, cx, cy;
		dx = gx - ox;
		dy = gy - oy;
		sx = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
		sy = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		kx = 0;
		ky = 0;
		cx = ox;
		cy = oy;
		for (int g = 0; g < 4 * DefMaxHalf + 4; g++) begin
			if (grid_map[cx][cy] == ST_OCCUPIED) return 1;
			if (cx == gx && cy == gy) return 0;
			if (ady == 0 || (adx != 0 && (kx + 1) * ady < (ky + 1) * adx)) begin
				cx += sx;
				kx++;
			end else begin
				cy += sy;
				ky++;
			end
			if (cx < 0 || cy < 0 || cx >= GRID_SIDE || cy >= GRID_SIDE) return 0;
		end
		return 0;
	endfunction

	// updates the grid copy and returns 1 when the word yields a collision answer
	function automatic bit apply_word(plan_row_t w, output bit hit);
		longint ix, iy, hv;
		hit = 0;
		hv = longint'(signed'(w.h));
		case (w.op)
			OP_FRAME: begin
				robot_px = longint'(signed'(w.x));
				robot_py = longint'(signed'(w.y));
				foreach (grid_map[i, j]) grid_map[i][j] = ST_UNKNOWN;
				return 0;
			end
			OP_POINT: begin
				ix = bin_index(longint'(signed'(w.x)), robot_px);
				iy = bin_index(longint'(signed'(w.y)), robot_py);
				if (hv > ground_lim && hv < over_lim)
					grid_map[ix][iy] = ST_OCCUPIED;
				else if (hv <= ground_lim && grid_map[ix][iy] != ST_OCCUPIED)
					grid_map[ix][iy] = ST_FREE;
				return 0;
			end
			OP_CHECK: begin
				hit = walk_blocked(bin_index(longint'(signed'(w.x)), robot_px),
					bin_index(longint'(signed'(w.y)), robot_py),
					bin_index(longint'(signed'(w.x2)), robot_px),
					bin_index(longint'(signed'(w.y2)), robot_py));
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	task automatic send_word(plan_row_t w);
		bit hit;
		while (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= w.op;
		x <= w.x;
		y <= w.y;
		height <= w.h;
		x2 <= w.x2;
		y2 <= w.y2;
		do @(posedge clk); while (!in_ready);
		if (apply_word(w, hit)) hit_queue.insert(hit_queue.size(), w.typed ? w.exp_hit : hit);
		@(negedge clk);
	endtask

	task automatic set_regs(logic [15:0] c, logic [15:0] hc, logic [15:0] g, logic [15:0] o);
		logic [15:0] vals [4];
		vals = '{c, hc, g, o};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		cell_len = c;
		half_len = hc[5:0];
		ground_lim = longint'(signed'(g));
		over_lim = longint'(signed'(o));
	endtask

	task automatic drain(int extra);
		in_valid <= 1'b0;
		while (hit_queue.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	function automatic logic [31:0] near(longint robot);
		longint c, span;
		c = (cell_len == 0) ? 1 : cell_len;
		span = (half_len + 3) * c;
		return 32'(robot + longint'($urandom_range(32'(2 * span))) - span);
	endfunction

	function automatic logic [15:0] pick_height();
		int r;
		r = $urandom_range(9);
		if (r < 3) return 16'(ground_lim + $urandom_range(2) - 1);
		if (r < 6) return 16'(over_lim + $urandom_range(2) - 1);
		if (r < 8) return 16'(ground_lim + $urandom_range(40) - 20);
		return 16'($urandom);
	endfunction

	function automatic plan_row_t random_word();
		plan_row_t w;
		int r;
		bit wild;
		r = $urandom_range(99);
		wild = $urandom_range(9) == 0;
		w.typed = 0;
		w.exp_hit = 0;
		w.h = 16'($urandom);
		w.x = $urandom;
		w.y = $urandom;
		w.x2 = $urandom;
		w.y2 = $urandom;
		if (r < 3) begin
			w.op = OP_FRAME;
			if (!wild) begin
				w.x = 32'($urandom_range(20000)) - 10000;
				w.y = 32'($urandom_range(20000)) - 10000;
			end
		end else if (r < 5) begin
			w.op = OP_SPARE;
		end else if (r < 70) begin
			w.op = OP_POINT;
			w.h = pick_height();
			if (!wild) begin
				w.x = near(robot_px);
				w.y = near(robot_py);
			end
		end else begin
			w.op = OP_CHECK;
			if (!wild) begin
				w.x = near(robot_px);
				w.y = near(robot_py);
				w.x2 = near(robot_px);
				w.y2 = near(robot_py);
			end
		end
		return w;
	endfunction

	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			out_ready <= 1'b0;
			hold_cnt++;
			if (hold_cnt >= 400) hold_done = 1;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 22);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (hit_queue.size() == 0) begin
				$error("collision: unexpected word, actual %0d", collision);
				errors++;
			end else begin
				bit exp_hit;
				exp_hit = hit_queue.pop_front();
				if (collision !== exp_hit) begin
					$error("collision: expected %0d actual %0d", exp_hit, collision);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CELL;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_FRAME;
		x = '0;
		y = '0;
		height = '0;
		x2 = '0;
		y2 = '0;
		out_ready = 1'b0;
		robot_px = 0;
		robot_py = 0;
		cell_len = 51;
		half_len = 63;
		ground_lim = 38;
		over_lim = 256;
		foreach (grid_map[i, j]) grid_map[i][j] = ST_UNKNOWN;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (plan[i]) send_word(plan[i]);
		n = 0;
		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				drain(CLEAR_WAIT);
				case (p)
					1: set_regs(16'd0, 16'd0, 16'h8000, 16'h7fff);
					2: set_regs(16'd7, 16'd5, 16'd0, 16'd100);
					3: set_regs(16'hffff, 16'd63, 16'h7fff, 16'h8000);
					default: set_regs(16'd200, 16'd20, 16'hffc0, 16'd300);
				endcase
			end
			for (int i = 0; i < 88; i++) begin
				n++;
				calm = (n >= 250 && n < 320);
				if (n == 150) hold_go = 1;
				send_word(random_word());
			end
		end
		calm = 0;
		drain(CHECK_WAIT);
		if (errors == 0 && hit_queue.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
